/* design/ceec_pkg.sv */
// Shared constants, types and tables for the covariance error-ellipse check.
`default_nettype none
package ceec_pkg;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 88;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_WARN  = 2'd1;
  localparam logic [1:0] REG_ERROR = 2'd2;

  localparam logic [15:0] SCALE_RESET = 16'd768;
  localparam logic [31:0] WARN_RESET  = 32'd52429;
  localparam logic [31:0] ERROR_RESET = 32'd65536;

  typedef enum logic [1:0] {
    ALARM_OK    = 2'd0,
    ALARM_WARN  = 2'd1,
    ALARM_ERROR = 2'd2
  } alarm_t;

  // Wide root of the squared difference plus four times the squared cross term.
  localparam int WR_IN_W    = 66;
  localparam int WR_OUT_W   = 34;
  localparam int WR_TRIAL_W = 68;

  // Root of an eigenvalue, shifted up so the root lands in Q16.16.
  localparam int RR_IN_W    = 49;
  localparam int RR_OUT_W   = 25;
  localparam int RR_TRIAL_W = 51;
  localparam int EIG_W      = 34;
  localparam int EIG_SHIFT  = 15;

  localparam int CORDIC_STAGES = 14;
  localparam int CORDIC_W      = 36;
  localparam int ANGLE_W       = 17;
  localparam int YAW_W         = 15;
  localparam logic signed [ANGLE_W-1:0] ANGLE_HALF = 17'sd16384;

  localparam logic signed [ANGLE_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
    17'sd4096, 17'sd2418, 17'sd1278, 17'sd649, 17'sd326, 17'sd163, 17'sd81,
    17'sd41, 17'sd20, 17'sd10, 17'sd5, 17'sd3, 17'sd1, 17'sd1
  };

  localparam int S_DLY   = WR_OUT_W;
  localparam int YAW_DLY = 48;

endpackage
`default_nettype wire

/* design/covariance_error_ellipse_check_unit.sv */
// Top level of the covariance error-ellipse check: register port, pipeline and output buffer.
//
// The s_ channel takes one 2x2 covariance per request (var_x, var_y, cov_xy in
// Q16.16). The m_ channel returns one result per request, in order: long and
// short semi-axis, major-axis yaw and the alarm level.
// Radius scale, warning limit and error limit are written through the APB port;
// the user must write them only while no request is in flight, as the block does
// not enforce it. pready is always high. The pipeline takes a request every cycle
// while the skid register is empty. Its depth is set by the 34-step root of the
// discriminant followed by the 25-step root of each eigenvalue, with the angle
// CORDIC running alongside.
// Reset clears all valid bits and loads the register defaults (scale 3.0,
// warning 0.8 m, error 1.0 m). When the receiver stalls, the output register
// holds its result and a skid register catches the next one; while the skid
// register is full the pipeline and s_tready stop, so nothing is lost.
`default_nettype none
module covariance_error_ellipse_check_unit
  import ceec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // var_x, var_y, cov_xy
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // semi_major, semi_minor, major_yaw,
                                                // alarm_level, zero fill
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  logic [15:0] radius_scale;
  logic [31:0] warn_limit;
  logic [31:0] error_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_scale <= SCALE_RESET;
      warn_limit   <= WARN_RESET;
      error_limit  <= ERROR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_SCALE: radius_scale <= pwdata[15:0];
        REG_WARN:  warn_limit   <= pwdata;
        REG_ERROR: error_limit  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE: prdata = {16'd0, radius_scale};
      REG_WARN:  prdata = warn_limit;
      REG_ERROR: prdata = error_limit;
      default:   prdata = '0;
    endcase
  end

  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // Stage A: sum, difference, cross term and magnitudes.
  logic [31:0]        in_vx;
  logic [31:0]        in_vy;
  logic signed [32:0] in_d;
  logic signed [32:0] in_c;
  logic [31:0]        in_absd;
  logic [31:0]        in_absc;

  assign in_vx   = s_tdata[31:0];
  assign in_vy   = s_tdata[63:32];
  assign in_d    = $signed({1'b0, in_vx}) - $signed({1'b0, in_vy});
  assign in_c    = $signed({s_tdata[95], s_tdata[95:64]});
  assign in_absd = (in_d < 0) ? 32'(-in_d) : 32'(in_d);
  assign in_absc = (in_c < 0) ? 32'(-in_c) : 32'(in_c);

  logic               v_a;
  logic [32:0]        s_a;
  logic signed [32:0] d_a;
  logic signed [32:0] c_a;
  logic [31:0]        absd_a;
  logic [31:0]        absc_a;

  always_ff @(posedge clk) begin
    if (en) begin
      s_a    <= {1'b0, in_vx} + {1'b0, in_vy};
      d_a    <= in_d;
      c_a    <= {in_c[31:0], 1'b0};
      absd_a <= in_absd;
      absc_a <= in_absc;
    end
  end

  // Stage B: squares. Stage C: discriminant.
  logic        v_b;
  logic [32:0] s_b;
  logic [63:0] sqd_b;
  logic [63:0] sqc_b;
  logic        v_c;
  logic [32:0] s_c;
  logic [WR_IN_W-1:0] disc_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s_b    <= s_a;
      sqd_b  <= absd_a * absd_a;
      sqc_b  <= absc_a * absc_a;
      s_c    <= s_b;
      disc_c <= WR_IN_W'(sqd_b) + {sqc_b, 2'b00};
    end
  end

  logic v_r;
  logic [WR_OUT_W-1:0] root_r;

  ceec_wide_root u_wide_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_c),
    .radicand  (disc_c),
    .out_valid (v_r),
    .root      (root_r)
  );

  logic [32:0] s_dly [S_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      s_dly[0] <= s_c;
      for (int i = 1; i < S_DLY; i++) begin
        s_dly[i] <= s_dly[i-1];
      end
    end
  end

  // Stage E: eigenvalues, the minor one clamped at zero.
  logic             v_e;
  logic [EIG_W-1:0] lmax_e;
  logic [EIG_W-1:0] lmin_e;
  logic [32:0]      s_end;

  assign s_end = s_dly[S_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      lmax_e <= EIG_W'(s_end) + root_r;
      lmin_e <= (EIG_W'(s_end) > root_r) ? EIG_W'(s_end) - root_r : '0;
    end
  end

  logic v_qmax;
  logic v_qmin;
  logic [RR_OUT_W-1:0] q_max;
  logic [RR_OUT_W-1:0] q_min;

  ceec_radius_root u_root_max (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_e),
    .radicand  ({lmax_e, EIG_SHIFT'(0)}),
    .out_valid (v_qmax),
    .root      (q_max)
  );

  ceec_radius_root u_root_min (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_e),
    .radicand  ({lmin_e, EIG_SHIFT'(0)}),
    .out_valid (v_qmin),
    .root      (q_min)
  );

  logic signed [YAW_W-1:0] yaw_c;
  logic [YAW_W-1:0]        yaw_dly [YAW_DLY];

  ceec_cordic u_cordic (
    .clk        (clk),
    .en         (en),
    .diff       (d_a),
    .cross_term (c_a),
    .yaw        (yaw_c)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_dly[0] <= yaw_c;
      for (int i = 1; i < YAW_DLY; i++) begin
        yaw_dly[i] <= yaw_dly[i-1];
      end
    end
  end

  // Stage G: scaling products.
  logic        v_g;
  logic [40:0] pmax_g;
  logic [40:0] pmin_g;

  always_ff @(posedge clk) begin
    if (en) begin
      pmax_g <= radius_scale * q_max;
      pmin_g <= radius_scale * q_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_e <= 1'b0;
      v_g <= 1'b0;
    end else if (en) begin
      v_a <= s_tvalid;
      v_b <= v_a;
      v_c <= v_b;
      v_e <= v_r;
      v_g <= v_qmax & v_qmin;
    end
  end

  logic [31:0] semi_major;
  logic [31:0] semi_minor;
  alarm_t      alarm_level;
  logic [OUT_DATA_W-1:0] res_data;

  assign semi_major = pmax_g[40] ? '1 : pmax_g[39:8];
  assign semi_minor = pmin_g[40] ? '1 : pmin_g[39:8];

  always_comb begin
    priority if (semi_major >= error_limit) begin
      alarm_level = ALARM_ERROR;
    end else if (semi_major >= warn_limit) begin
      alarm_level = ALARM_WARN;
    end else begin
      alarm_level = ALARM_OK;
    end
  end

  assign res_data = {7'd0, alarm_level, yaw_dly[YAW_DLY-1], semi_minor, semi_major};

  logic [OUT_DATA_W-1:0] skid_data;
  logic                  out_load;

  assign out_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= v_g;
      end
    end else if (en && v_g) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= skid_valid ? skid_data : res_data;
    end else if (en) begin
      skid_data <= res_data;
    end
  end

endmodule
`default_nettype wire

/* design/ceec_wide_root.sv */
// Pipelined bit-per-stage floor square root of the 66-bit discriminant.
`default_nettype none
module ceec_wide_root
  import ceec_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [WR_IN_W-1:0]  radicand,
  output logic                     out_valid,
  output logic [WR_OUT_W-1:0]      root
);

  logic [WR_IN_W-1:0]  rem_q [WR_OUT_W];
  logic [WR_OUT_W-1:0] res_q [WR_OUT_W];
  logic [WR_OUT_W-1:0] vld_q;

  for (genvar j = 0; j < WR_OUT_W; j++) begin : g_step
    logic [WR_IN_W-1:0]    rem_in;
    logic [WR_IN_W-1:0]    rem_nx;
    logic [WR_OUT_W-1:0]   res_in;
    logic [WR_OUT_W-1:0]   res_nx;
    logic                  v_in;
    logic [WR_TRIAL_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
      assign v_in   = vld_q[j-1];
    end

    always_comb begin
      trial = (WR_TRIAL_W'(res_in) << (WR_OUT_W - j)) |
              (WR_TRIAL_W'(1) << (2 * (WR_OUT_W - 1 - j)));
      if (trial <= WR_TRIAL_W'(rem_in)) begin
        rem_nx = rem_in - WR_IN_W'(trial);
        res_nx = res_in | (WR_OUT_W'(1) << (WR_OUT_W - 1 - j));
      end else begin
        rem_nx = rem_in;
        res_nx = res_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= rem_nx;
        res_q[j] <= res_nx;
      end
    end
  end

  assign out_valid = vld_q[WR_OUT_W-1];
  assign root      = res_q[WR_OUT_W-1];

endmodule
`default_nettype wire

/* design/ceec_radius_root.sv */
// Pipelined bit-per-stage floor square root of one scaled eigenvalue.
`default_nettype none
module ceec_radius_root
  import ceec_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [RR_IN_W-1:0]  radicand,
  output logic                     out_valid,
  output logic [RR_OUT_W-1:0]      root
);

  logic [RR_IN_W-1:0]  rem_q [RR_OUT_W];
  logic [RR_OUT_W-1:0] res_q [RR_OUT_W];
  logic [RR_OUT_W-1:0] vld_q;

  for (genvar j = 0; j < RR_OUT_W; j++) begin : g_step
    logic [RR_IN_W-1:0]    rem_in;
    logic [RR_IN_W-1:0]    rem_nx;
    logic [RR_OUT_W-1:0]   res_in;
    logic [RR_OUT_W-1:0]   res_nx;
    logic                  v_in;
    logic [RR_TRIAL_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
      assign v_in   = vld_q[j-1];
    end

    always_comb begin
      trial = (RR_TRIAL_W'(res_in) << (RR_OUT_W - j)) |
              (RR_TRIAL_W'(1) << (2 * (RR_OUT_W - 1 - j)));
      if (trial <= RR_TRIAL_W'(rem_in)) begin
        rem_nx = rem_in - RR_IN_W'(trial);
        res_nx = res_in | (RR_OUT_W'(1) << (RR_OUT_W - 1 - j));
      end else begin
        rem_nx = rem_in;
        res_nx = res_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= rem_nx;
        res_q[j] <= res_nx;
      end
    end
  end

  assign out_valid = vld_q[RR_OUT_W-1];
  assign root      = res_q[RR_OUT_W-1];

endmodule
`default_nettype wire

/* design/ceec_cordic.sv */
// Pipelined vectoring CORDIC giving the major-axis angle from the difference and cross term.
`default_nettype none
module ceec_cordic
  import ceec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] diff,
  input  wire logic signed [32:0] cross_term,
  output logic signed [YAW_W-1:0] yaw
);

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0]  z_q [CORDIC_STAGES+1];

  // Vectors in the left half plane are turned by pi first.
  always_ff @(posedge clk) begin
    if (en) begin
      if (diff < 0) begin
        x_q[0] <= -CORDIC_W'(diff);
        y_q[0] <= -CORDIC_W'(cross_term);
        z_q[0] <= (cross_term >= 0) ? ANGLE_HALF : -ANGLE_HALF;
      end else begin
        x_q[0] <= CORDIC_W'(diff);
        y_q[0] <= CORDIC_W'(cross_term);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + ATAN_TAB[i];
        end else if (y_q[i] < 0) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i];
          y_q[i+1] <= y_q[i];
          z_q[i+1] <= z_q[i];
        end
      end
    end
  end

  // Wrapping into [-pi/2, pi/2) is the low bits in two's complement.
  assign yaw = z_q[CORDIC_STAGES][YAW_W-1:0];

endmodule
`default_nettype wire

/* design/ceec_checker.sv */
// Port-level checks on the covariance error-ellipse check unit, bound to the top level.
`default_nettype none
module ceec_checker
  import ceec_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_alarm_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[80:79] != 2'd3)
    else $error("alarm level out of range");

  a_axis_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[63:32] <= m_tdata[31:0])
    else $error("minor semi-axis exceeds major semi-axis");

  a_error_wins: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:0] == 32'hFFFF_FFFF |-> m_tdata[80:79] == ALARM_ERROR)
    else $error("saturated semi-axis without error alarm");

endmodule

bind covariance_error_ellipse_check_unit ceec_checker u_ceec_checker (.*);
`default_nettype wire
